// ----- hw/rtl/opsel_pkg.sv -----
// Shared types and constants for the ordinal point selector.
`timescale 1ns / 1ps

package opsel_pkg;

  // Fixed field widths of the register file and result payload.
  localparam int REG_W      = 48;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int KIND_W     = 2;

  // Defaults for the top-level parameters.
  localparam int DefIndexBits    = 48;
  localparam int DefStepFracBits = 16;

  // Selection modes held in the filter kind register.
  localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAIL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DECIM = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FIXED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_POINTS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT     = 3'd7;

  // Configuration register file contents.
  typedef struct packed {
    logic [KIND_W-1:0] filter_kind;
    logic              invert_select;
    logic [REG_W-1:0]  keep_count;
    logic [REG_W-1:0]  step_fixed;
    logic [REG_W-1:0]  start_offset;
    logic [REG_W-1:0]  point_limit;
    logic [REG_W-1:0]  total_points;
    logic [REG_W-1:0]  sequence_limit;
  } cfg_t;

  // Decimation tracking state carried from one point to the next.
  typedef struct packed {
    logic [REG_W-1:0] sequence_index;
    logic [ACC_W-1:0] step_accumulator;
  } decim_state_t;

endpackage

// ----- hw/rtl/opsel_if.sv -----
// Request and result channel interfaces of the ordinal point selector.
`timescale 1ns / 1ps

interface opsel_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface opsel_out_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [47:0] point_index;

  modport source (output valid, output keep, output point_index, input ready);
  modport sink (input valid, input keep, input point_index, output ready);
endinterface

// ----- hw/rtl/opsel_pick.sv -----
// Per-point keep decision and next-state computation.
`timescale 1ns / 1ps

module opsel_pick import opsel_pkg::*; #(
  parameter int INDEX_BITS     = DefIndexBits,
  parameter int STEP_FRAC_BITS = DefStepFracBits
) (
  input  cfg_t                  cfg_i,
  input  logic                  restart_i,
  input  logic [INDEX_BITS-1:0] counter_i,
  input  decim_state_t          state_i,
  output logic                  keep_o,
  output logic [REG_W-1:0]      point_index_o,
  output logic [INDEX_BITS-1:0] counter_o,
  output decim_state_t          state_o
);

  localparam int CmpW = (INDEX_BITS > REG_W) ? INDEX_BITS : REG_W;
  localparam int SumW = ACC_W + 2;
  localparam logic [INDEX_BITS-1:0] IdxMax = '1;
  localparam logic [REG_W-1:0] StepOne = REG_W'(1) << STEP_FRAC_BITS;

  logic [INDEX_BITS-1:0] p;
  logic [ACC_W-1:0]      acc;
  logic [REG_W-1:0]      seq;
  logic [CmpW-1:0]       p_ext;
  logic [SumW-1:0]       cand_sum;
  logic [INDEX_BITS-1:0] cand;
  logic [REG_W-1:0]      tail_sel;
  logic [REG_W-1:0]      tail_start;
  logic                  take;
  logic [REG_W-1:0]      step;
  logic [ACC_W:0]        acc_sum;

  // A restart clears the running state before this point is handled.
  assign p     = restart_i ? '0 : counter_i;
  assign acc   = restart_i ? '0 : state_i.step_accumulator;
  assign seq   = restart_i ? '0 : state_i.sequence_index;
  assign p_ext = CmpW'(p);

  // Pending candidate: offset plus the rounded accumulator. The half bit
  // enters as the carry-in, so this stays a single adder.
  assign cand_sum = SumW'(cfg_i.start_offset) + SumW'(acc[ACC_W-1:STEP_FRAC_BITS])
                  + SumW'(acc[STEP_FRAC_BITS-1]);
  assign cand = (cand_sum >= SumW'(IdxMax)) ? IdxMax : cand_sum[INDEX_BITS-1:0];

  // Tail keeps everything from total minus the clamped count onward.
  assign tail_sel   = (cfg_i.keep_count < cfg_i.total_points) ? cfg_i.keep_count
                                                               : cfg_i.total_points;
  assign tail_start = cfg_i.total_points - tail_sel;

  // A decimation candidate is consumed when it is due or already behind, while below the sequence and point limits.
  assign take = (seq < cfg_i.sequence_limit) && (p_ext < CmpW'(cfg_i.point_limit))
             && (cand <= p);

  assign step    = (cfg_i.step_fixed < StepOne) ? StepOne : cfg_i.step_fixed;
  assign acc_sum = {1'b0, acc} + (ACC_W + 1)'(step);

  // Keep decision and decimation state update.
  always_comb begin
    keep_o  = 1'b0;
    state_o = '{sequence_index: seq, step_accumulator: acc};
    case (cfg_i.filter_kind)
      KIND_HEAD: begin
        keep_o = (p_ext < CmpW'(cfg_i.keep_count)) ^ cfg_i.invert_select;
      end
      KIND_TAIL: begin
        keep_o = (p_ext >= CmpW'(tail_start)) ^ cfg_i.invert_select;
      end
      KIND_DECIM: begin
        if (take) begin
          keep_o = (cand == p);
          state_o.sequence_index   = (&seq) ? seq : seq + REG_W'(1);
          state_o.step_accumulator = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        end
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

  // The point index saturates at its maximum.
  assign counter_o     = (&p) ? p : p + INDEX_BITS'(1);
  assign point_index_o = p_ext[REG_W-1:0];

endmodule

// ----- hw/rtl/opsel_skid.sv -----
// Two-entry result buffer that decouples the request side from the result side.
`timescale 1ns / 1ps

module opsel_skid import opsel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             keep_i,
  input  logic [REG_W-1:0] index_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic             keep_o,
  output logic [REG_W-1:0] index_o
);

  logic             out_valid_q, out_valid_d;
  logic             out_keep_q, out_keep_d;
  logic [REG_W-1:0] out_index_q, out_index_d;
  logic             skid_valid_q, skid_valid_d;
  logic             skid_keep_q, skid_keep_d;
  logic [REG_W-1:0] skid_index_q, skid_index_d;
  logic             out_free;

  assign out_free = !out_valid_q || ready_i;

  // The output stage refills from the skid entry first, then from a new result.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_keep_d   = out_keep_q;
    out_index_d  = out_index_q;
    skid_valid_d = skid_valid_q;
    skid_keep_d  = skid_keep_q;
    skid_index_d = skid_index_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || push_i;
      out_keep_d   = skid_valid_q ? skid_keep_q : keep_i;
      out_index_d  = skid_valid_q ? skid_index_q : index_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_keep_d  = keep_i;
      skid_index_d = index_i;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_keep_q   <= out_keep_d;
    out_index_q  <= out_index_d;
    skid_keep_q  <= skid_keep_d;
    skid_index_q <= skid_index_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign keep_o  = out_keep_q;
  assign index_o = out_index_q;

  // The skid entry is only used behind a held output entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output stage is empty");

endmodule

// ----- hw/rtl/ordinal_point_selector_core.sv -----
// Top level of the ordinal point selector: registers, state and result buffer.
`timescale 1ns / 1ps

// Head, tail or decimation selection over a stream of points.
// Each request on in_req is one point; its restart bit clears the point
// index and the decimation sequence before that point is handled. For each
// request one result appears on out_rsp: the point's running index and its
// keep flag. Results leave in request order.
// A result is registered in the buffer's output entry, or its skid entry if
// the output is held. One point per cycle while in_req.ready is high; the point
// counter and decimation accumulator update in that cycle, setting the rate.
// A two-entry result buffer lets a request be accepted while an earlier
// result still waits; in_req.ready drops only when both entries are held
// by a stalled receiver.
// Reset clears the counters, empties the buffer and loads the register
// defaults: head mode, step 1.0, point and sequence limits all ones.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must do so only while no point is in flight, which the block does not enforce.
module ordinal_point_selector_core import opsel_pkg::*; #(
  parameter int INDEX_BITS     = DefIndexBits,
  parameter int STEP_FRAC_BITS = DefStepFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  opsel_in_if.sink             in_req,
  opsel_out_if.source          out_rsp
);

  localparam logic [REG_W-1:0] StepOne = REG_W'(1) << STEP_FRAC_BITS;

  cfg_t                  cfg_q;
  logic [INDEX_BITS-1:0] counter_q, counter_d;
  decim_state_t          state_q, state_d;
  logic                  in_fire;
  logic                  skid_full;
  logic                  keep;
  logic [REG_W-1:0]      point_index;

  assign in_req.ready = !skid_full;
  assign in_fire      = in_req.valid && in_req.ready;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_kind    <= KIND_HEAD;
      cfg_q.invert_select  <= 1'b0;
      cfg_q.keep_count     <= '0;
      cfg_q.step_fixed     <= StepOne;
      cfg_q.start_offset   <= '0;
      cfg_q.point_limit    <= '1;
      cfg_q.total_points   <= '0;
      cfg_q.sequence_limit <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FILTER_KIND:   cfg_q.filter_kind    <= cfg_wdata_i[KIND_W-1:0];
        REG_INVERT_SELECT: cfg_q.invert_select  <= cfg_wdata_i[0];
        REG_KEEP_COUNT:    cfg_q.keep_count     <= cfg_wdata_i;
        REG_STEP_FIXED:    cfg_q.step_fixed     <= cfg_wdata_i;
        REG_START_OFFSET:  cfg_q.start_offset   <= cfg_wdata_i;
        REG_POINT_LIMIT:   cfg_q.point_limit    <= cfg_wdata_i;
        REG_TOTAL_POINTS:  cfg_q.total_points   <= cfg_wdata_i;
        REG_SEQ_LIMIT:     cfg_q.sequence_limit <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Keep decision for the incoming point.
  opsel_pick #(
    .INDEX_BITS     (INDEX_BITS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_pick (
    .cfg_i         (cfg_q),
    .restart_i     (in_req.restart),
    .counter_i     (counter_q),
    .state_i       (state_q),
    .keep_o        (keep),
    .point_index_o (point_index),
    .counter_o     (counter_d),
    .state_o       (state_d)
  );

  // Running state advances once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      state_q   <= '0;
    end else if (in_fire) begin
      counter_q <= counter_d;
      state_q   <= state_d;
    end
  end

  // Result buffer toward the receiver.
  opsel_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .keep_i  (keep),
    .index_i (point_index),
    .full_o  (skid_full),
    .valid_o (out_rsp.valid),
    .ready_i (out_rsp.ready),
    .keep_o  (out_rsp.keep),
    .index_o (out_rsp.point_index)
  );

  // A restart request leaves the counter one past index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req.restart |=> counter_q == INDEX_BITS'(1))
    else $error("point counter did not restart");

  // Head and tail modes never touch the decimation sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_req.restart && cfg_q.filter_kind != KIND_DECIM
    |=> state_q == $past(state_q))
    else $error("decimation state changed outside decimation mode");

  // Without a restart the step accumulator never moves backward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_req.restart
    |=> state_q.step_accumulator >= $past(state_q.step_accumulator))
    else $error("step accumulator decreased");

  // After every accepted request, the output holds a valid result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> out_rsp.valid)
    else $error("accepted request produced no result");

endmodule
